// ----- design/pfe_pkg.sv -----
// Shared constants, types and helper functions of the page framebuffer engine.
// Used by pfe_store and page_framebuffer_engine. No dependencies.
`default_nettype none

package pfe_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W        = $clog2(STORE_BYTES);
   localparam int CMD_BYTES     = 6;
   localparam int POS_W         = $clog2(CMD_BYTES + STORE_BYTES + 1);
   localparam int GLYPH_ROWS    = 7;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;

   // Result flag positions in rsp_tuser.
   localparam int RSP_DATA_BIT = 0;
   localparam int RSP_SKIP_BIT = 1;

   // Operation codes carried in req_tuser.
   localparam logic [2:0] KIND_PIXEL = 3'd0;
   localparam logic [2:0] KIND_LINE  = 3'd1;
   localparam logic [2:0] KIND_GLYPH = 3'd2;
   localparam logic [2:0] KIND_CLEAR = 3'd3;
   localparam logic [2:0] KIND_FLUSH = 3'd4;

   // Display window commands.
   localparam logic [7:0] CMD_COLUMN_ADDR = 8'h21;
   localparam logic [7:0] CMD_PAGE_ADDR   = 8'h22;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } store_rd_type;

   typedef struct packed {
      logic              en;
      logic              clear;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        mask;
      logic              lit;
   } store_wr_type;

   // Byte index of an on-screen pixel: column plus page times width.
   function automatic logic [ADDR_W-1:0] pix_addr(input logic [7:0] x, input logic [7:0] y);
      logic [16:0] a;
      a = 17'(x) + 17'(y[7:3]) * 17'(SCREEN_WIDTH);
      return a[ADDR_W-1:0];
   endfunction

   // Window command sequence: column range, then page range.
   function automatic logic [7:0] cmd_byte(input logic [2:0] pos);
      logic [7:0] b;
      case (pos)
         3'd0: b = CMD_COLUMN_ADDR;
         3'd1: b = 8'h00;
         3'd2: b = 8'(SCREEN_WIDTH - 1);
         3'd3: b = CMD_PAGE_ADDR;
         3'd4: b = 8'h00;
         default: b = 8'(PAGE_COUNT - 1);
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ----- design/pfe_store.sv -----
// Page byte store of the framebuffer engine: one synchronous memory with a
// registered read port and a masked bit update on the write side. Uses pfe_pkg.
`default_nettype none

module pfe_store (
   input  wire logic                  clock,
   input  wire pfe_pkg::store_rd_type rd,
   input  wire pfe_pkg::store_wr_type wr,
   output logic [7:0]                 rd_data
);
   import pfe_pkg::*;

   logic [7:0] mem_ff [STORE_BYTES];
   logic [7:0] rd_data_ff;
   logic [7:0] wr_data;

   // The write clears the byte, or merges the pixel into the byte held in the read register.
   always_comb begin
      if (wr.clear) begin
         wr_data = 8'h00;
      end else if (wr.lit) begin
         wr_data = rd_data_ff | wr.mask;
      end else begin
         wr_data = rd_data_ff & ~wr.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr_data;
      end
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/page_framebuffer_engine.sv -----
// Top level of the page framebuffer engine: command decoder, pixel sequencer,
// flush sequencer and output register. Uses pfe_pkg and pfe_store.
// Steps: a pixel passes ST_PIX, a store read (ST_RD) and the merged write (ST_WR) before
// the next item is taken; a line and a glyph column do so for each pixel on the screen and
// only pass the others; a clear sweeps the store one byte a cycle. A flush command item
// goes straight to ST_EMIT and a data item first reads the store (ST_FRD); the next item can
// be taken in the cycle the item is offered, and a step waits while an earlier result still
// sits in the output register. Reset is synchronous; afterwards the store is swept to zero,
// one byte a cycle, and no item is accepted until the sweep is done.
`default_nettype none

module page_framebuffer_engine (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // x_pos [7:0], y_pos [15:8], x_end [23:16], pixel_on [24], column_bits [31:25]
   input  wire logic [pfe_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind [2:0]
   input  wire logic [pfe_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // out_byte [7:0]
   output logic [pfe_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // last_byte
   output logic                                  rsp_tlast,
   // is_data [0], skipped [1]
   output logic [pfe_pkg::RSP_USER_W-1:0]        rsp_tuser
);
   import pfe_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_PIX   = 7'b0000100,
      ST_RD    = 7'b0001000,
      ST_WR    = 7'b0010000,
      ST_FRD   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   // Control registers.
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              dirty_ff, dirty_in;
   logic              active_ff, active_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers of the item at work.
   logic [2:0]        kind_ff, kind_in;
   logic [7:0]        x_ff, x_in;
   logic [7:0]        x_end_ff, x_end_in;
   logic [7:0]        y_ff, y_in;
   logic              on_ff, on_in;
   logic [6:0]        bits_ff, bits_in;
   logic [2:0]        row_ff, row_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]        mask_ff, mask_in;
   logic              lit_ff, lit_in;
   logic              last_ff, last_in;
   logic [7:0]        pend_byte_ff, pend_byte_in;
   logic              pend_data_ff, pend_data_in;
   logic              pend_last_ff, pend_last_in;
   logic              pend_skip_ff, pend_skip_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_skip_ff, rsp_skip_in;

   // Unpacked input fields.
   logic       accept;
   logic [2:0] in_kind;
   logic [7:0] in_x, in_y, in_x_end;
   logic       in_on;
   logic [6:0] in_bits;

   // Line end points after ordering and clipping.
   logic [7:0] line_lo, line_hi_raw, line_hi;

   // Current pixel of the drawing sequencer.
   logic [7:0] pix_y;
   logic       pix_lit, pix_vis, pix_last;

   // Flush bookkeeping.
   logic [POS_W-1:0] cur_pos, data_idx;

   store_rd_type store_rd;
   store_wr_type store_wr;
   logic [7:0]   store_rd_data;

   pfe_store u_store (
      .clock   (clock),
      .rd      (store_rd),
      .wr      (store_wr),
      .rd_data (store_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign in_kind  = req_tuser;
   assign in_x     = req_tdata[7:0];
   assign in_y     = req_tdata[15:8];
   assign in_x_end = req_tdata[23:16];
   assign in_on    = req_tdata[24];
   assign in_bits  = req_tdata[31:25];

   // A line is drawn from its lower to its higher column, the right end clipped
   // to the last column. When the left end lies past the screen nothing is drawn.
   always_comb begin
      if (in_x_end < in_x) begin
         line_lo     = in_x_end;
         line_hi_raw = in_x;
      end else begin
         line_lo     = in_x;
         line_hi_raw = in_x_end;
      end
      if ({1'b0, line_hi_raw} > 9'(SCREEN_WIDTH - 1)) begin
         line_hi = 8'(SCREEN_WIDTH - 1);
      end else begin
         line_hi = line_hi_raw;
      end
   end

   // The glyph rows wrap at 256 before they are clipped against the screen.
   always_comb begin
      if (kind_ff == KIND_GLYPH) begin
         pix_y = y_ff + 8'(row_ff);
      end else begin
         pix_y = y_ff;
      end
      case (kind_ff)
         KIND_LINE:  pix_lit = 1'b1;
         KIND_GLYPH: pix_lit = bits_ff[row_ff];
         default:    pix_lit = on_ff;
      endcase
      case (kind_ff)
         KIND_LINE:  pix_last = (x_ff == x_end_ff);
         KIND_GLYPH: pix_last = (row_ff == 3'(GLYPH_ROWS - 1));
         default:    pix_last = 1'b1;
      endcase
      pix_vis = ({1'b0, x_ff} < 9'(SCREEN_WIDTH)) && ({1'b0, pix_y} < 9'(SCREEN_HEIGHT));
   end

   // A flush that has not started begins at the first window command.
   assign cur_pos = active_ff ? pos_ff : '0;

   always_comb begin
      if (cur_pos - POS_W'(CMD_BYTES) > POS_W'(STORE_BYTES - 1)) begin
         data_idx = POS_W'(STORE_BYTES - 1);
      end else begin
         data_idx = cur_pos - POS_W'(CMD_BYTES);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      dirty_in     = dirty_ff;
      active_in    = active_ff;
      pos_in       = pos_ff;
      kind_in      = kind_ff;
      x_in         = x_ff;
      x_end_in     = x_end_ff;
      y_in         = y_ff;
      on_in        = on_ff;
      bits_in      = bits_ff;
      row_in       = row_ff;
      addr_in      = addr_ff;
      mask_in      = mask_ff;
      lit_in       = lit_ff;
      last_in      = last_ff;
      pend_byte_in = pend_byte_ff;
      pend_data_in = pend_data_ff;
      pend_last_in = pend_last_ff;
      pend_skip_in = pend_skip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_skip_in  = rsp_skip_ff;

      store_rd.en    = 1'b0;
      store_rd.addr  = addr_ff;
      store_wr.en    = 1'b0;
      store_wr.clear = 1'b0;
      store_wr.addr  = addr_ff;
      store_wr.mask  = mask_ff;
      store_wr.lit   = lit_ff;

      case (state_ff)
         ST_CLEAR: begin
            // One byte a cycle, after reset and for a clear item.
            store_wr.en    = 1'b1;
            store_wr.clear = 1'b1;
            store_wr.addr  = clr_cnt_ff;
            clr_cnt_in     = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(STORE_BYTES - 1)) begin
               clr_cnt_in = '0;
               state_in   = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in  = in_kind;
               x_in     = in_x;
               x_end_in = in_x_end;
               y_in     = in_y;
               on_in    = in_on;
               bits_in  = in_bits;
               row_in   = '0;
               case (in_kind)
                  KIND_PIXEL: begin
                     state_in = ST_PIX;
                  end
                  KIND_LINE: begin
                     x_in     = line_lo;
                     x_end_in = line_hi;
                     if (line_lo <= line_hi) begin
                        state_in = ST_PIX;
                     end
                  end
                  KIND_GLYPH: begin
                     state_in = ST_PIX;
                  end
                  KIND_CLEAR: begin
                     dirty_in   = 1'b1;
                     clr_cnt_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  KIND_FLUSH: begin
                     if (!active_ff && !dirty_ff) begin
                        // Nothing to send: a single skip item.
                        pend_byte_in = 8'h00;
                        pend_data_in = 1'b0;
                        pend_last_in = 1'b1;
                        pend_skip_in = 1'b1;
                        state_in     = ST_EMIT;
                     end else begin
                        if (!active_ff) begin
                           dirty_in  = 1'b0;
                           active_in = 1'b1;
                        end
                        pend_skip_in = 1'b0;
                        if (cur_pos < POS_W'(CMD_BYTES)) begin
                           pend_byte_in = cmd_byte(cur_pos[2:0]);
                           pend_data_in = 1'b0;
                           pend_last_in = 1'b0;
                           pos_in       = cur_pos + 1'b1;
                           state_in     = ST_EMIT;
                        end else begin
                           addr_in      = data_idx[ADDR_W-1:0];
                           pend_data_in = 1'b1;
                           if (data_idx >= POS_W'(STORE_BYTES - 1)) begin
                              pend_last_in = 1'b1;
                              active_in    = 1'b0;
                              pos_in       = '0;
                           end else begin
                              pend_last_in = 1'b0;
                              pos_in       = cur_pos + 1'b1;
                           end
                           state_in = ST_FRD;
                        end
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_PIX: begin
            if (pix_vis) begin
               addr_in  = pix_addr(x_ff, pix_y);
               mask_in  = 8'd1 << pix_y[2:0];
               lit_in   = pix_lit;
               last_in  = pix_last;
               state_in = ST_RD;
            end else if (pix_last) begin
               state_in = ST_IDLE;
            end else if (kind_ff == KIND_LINE) begin
               x_in = x_ff + 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ST_RD: begin
            store_rd.en = 1'b1;
            state_in    = ST_WR;
         end
         ST_WR: begin
            store_wr.en = 1'b1;
            dirty_in    = 1'b1;
            if (last_ff) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_PIX;
               if (kind_ff == KIND_LINE) begin
                  x_in = x_ff + 1'b1;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         ST_FRD: begin
            store_rd.en = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            // Wait for the output register to be free, then hand the item over.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = pend_data_ff ? store_rd_data : pend_byte_ff;
               rsp_data_in  = pend_data_ff;
               rsp_last_in  = pend_last_ff;
               rsp_skip_in  = pend_skip_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         dirty_ff     <= 1'b1;
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         dirty_ff     <= dirty_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      x_ff         <= x_in;
      x_end_ff     <= x_end_in;
      y_ff         <= y_in;
      on_ff        <= on_in;
      bits_ff      <= bits_in;
      row_ff       <= row_in;
      addr_ff      <= addr_in;
      mask_ff      <= mask_in;
      lit_ff       <= lit_in;
      last_ff      <= last_in;
      pend_byte_ff <= pend_byte_in;
      pend_data_ff <= pend_data_in;
      pend_last_ff <= pend_last_in;
      pend_skip_ff <= pend_skip_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_skip_ff  <= rsp_skip_in;
   end

   assign rsp_tvalid              = rsp_valid_ff;
   assign rsp_tdata               = rsp_byte_ff;
   assign rsp_tlast               = rsp_last_ff;
   assign rsp_tuser[RSP_DATA_BIT] = rsp_data_ff;
   assign rsp_tuser[RSP_SKIP_BIT] = rsp_skip_ff;

   // A skip item is always a lone, empty, final command item.
   a_skip_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[RSP_SKIP_BIT]) |->
         (rsp_tlast && rsp_tdata == 8'h00 && !rsp_tuser[RSP_DATA_BIT]))
      else $error("skip item with unexpected fields");

   // The flush position rests at zero between flushes.
   a_pos_idle: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (pos_ff == '0))
      else $error("flush position not zero outside a flush");

   // Every pixel written to the store marks the frame dirty.
   a_write_dirty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |=> dirty_ff)
      else $error("pixel write left the frame clean");

   // Starting a flush takes the dirty mark and opens the flush.
   a_flush_start: assert property (@(posedge clock) disable iff (reset)
      (accept && in_kind == KIND_FLUSH && !active_ff && dirty_ff) |=>
         (active_ff && !dirty_ff))
      else $error("flush start did not open the flush");

endmodule

`default_nettype wire
